FILE: design/nts_pkg.sv
// Shared widths, reset values, register indexes and stage payload types
// for the nearest target selector. No dependencies.
`default_nettype none

package nts_pkg;

    // Coordinate and derived widths
    localparam int COORD_W   = 14;
    localparam int RAD_W     = COORD_W - 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int RAD_SQ_W  = 2 * RAD_W;
    localparam int CFG_IDX_W = 3;

    // Stream payload widths, tdata packed to whole bytes
    localparam int S_TDATA_W = ((4 * COORD_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    // Register reset values
    localparam int ARENA_LOW_RST  = 0;
    localparam int ARENA_HIGH_RST = 2100;
    localparam int RADIUS_RST     = 300;
    localparam int HOME_X_RST     = 250;
    localparam int HOME_Y_RST     = 250;
    localparam int LIMIT_RST      = 3000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARENA_LOW  = 3'd0,
        REG_ARENA_HIGH = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_HOME_X     = 3'd3,
        REG_HOME_Y     = 3'd4,
        REG_LIMIT      = 3'd5
    } t_cfg_idx;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [COORD_W-1:0] arena_low;
        logic signed [COORD_W-1:0] arena_high;
        logic signed [COORD_W-1:0] home_x;
        logic signed [COORD_W-1:0] home_y;
        logic        [RAD_SQ_W-1:0] rad_sq;
        logic        [SQ_W-1:0]     lim_sq;
    } t_cfg;

    // Item after the squaring stage
    typedef struct packed {
        logic                      first;
        logic                      last;
        logic                      ok;
        logic        [SQ_W-1:0]    hx2;
        logic        [SQ_W-1:0]    hy2;
        logic        [SQ_W-1:0]    rx2;
        logic        [SQ_W-1:0]    ry2;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
    } t_sq_item;

    // Square of a coordinate difference; always fits in SQ_W bits
    function automatic logic [SQ_W-1:0] sq_diff(input logic signed [DIFF_W-1:0] d);
        logic signed [2*DIFF_W-1:0] p;
        p = d * d;
        return p[SQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/nts_cfg.sv
// Configuration register file with registered squares of radius and limit.
// Depends on nts_pkg.
`default_nettype none

module nts_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [nts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [nts_pkg::COORD_W-1:0]       i_cfg_data,
    output nts_pkg::t_cfg                          o_cfg
);

    logic signed [nts_pkg::COORD_W-1:0] r_arena_low;
    logic signed [nts_pkg::COORD_W-1:0] r_arena_high;
    logic        [nts_pkg::RAD_W-1:0]   r_radius;
    logic signed [nts_pkg::COORD_W-1:0] r_home_x;
    logic signed [nts_pkg::COORD_W-1:0] r_home_y;
    logic        [nts_pkg::COORD_W-1:0] r_limit;
    logic        [nts_pkg::RAD_SQ_W-1:0] r_rad_sq;
    logic        [nts_pkg::SQ_W-1:0]     r_lim_sq;
    logic        [nts_pkg::RAD_SQ_W-1:0] n_rad_sq;
    logic        [nts_pkg::SQ_W-1:0]     n_lim_sq;

    // Square the radius and limit once, off the item path
    assign n_rad_sq = nts_pkg::RAD_SQ_W'(r_radius) * nts_pkg::RAD_SQ_W'(r_radius);
    assign n_lim_sq = nts_pkg::SQ_W'(r_limit) * nts_pkg::SQ_W'(r_limit);

    // Write registers by index; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_low  <= nts_pkg::COORD_W'(nts_pkg::ARENA_LOW_RST);
            r_arena_high <= nts_pkg::COORD_W'(nts_pkg::ARENA_HIGH_RST);
            r_radius     <= nts_pkg::RAD_W'(nts_pkg::RADIUS_RST);
            r_home_x     <= nts_pkg::COORD_W'(nts_pkg::HOME_X_RST);
            r_home_y     <= nts_pkg::COORD_W'(nts_pkg::HOME_Y_RST);
            r_limit      <= nts_pkg::COORD_W'(nts_pkg::LIMIT_RST);
            r_rad_sq     <= nts_pkg::RAD_SQ_W'(nts_pkg::RADIUS_RST * nts_pkg::RADIUS_RST);
            r_lim_sq     <= nts_pkg::SQ_W'(nts_pkg::LIMIT_RST * nts_pkg::LIMIT_RST);
        end else begin
            r_rad_sq <= n_rad_sq;
            r_lim_sq <= n_lim_sq;
            if (i_cfg_we) begin
                case (nts_pkg::t_cfg_idx'(i_cfg_idx))
                    nts_pkg::REG_ARENA_LOW:  r_arena_low  <= i_cfg_data;
                    nts_pkg::REG_ARENA_HIGH: r_arena_high <= i_cfg_data;
                    nts_pkg::REG_RADIUS:     r_radius     <= i_cfg_data[nts_pkg::RAD_W-1:0];
                    nts_pkg::REG_HOME_X:     r_home_x     <= i_cfg_data;
                    nts_pkg::REG_HOME_Y:     r_home_y     <= i_cfg_data;
                    nts_pkg::REG_LIMIT:      r_limit      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Present configuration to the datapath
    always_comb begin
        o_cfg.arena_low  = r_arena_low;
        o_cfg.arena_high = r_arena_high;
        o_cfg.home_x     = r_home_x;
        o_cfg.home_y     = r_home_y;
        o_cfg.rad_sq     = r_rad_sq;
        o_cfg.lim_sq     = r_lim_sq;
    end

endmodule

`default_nettype wire

FILE: design/nts_square.sv
// Input register, robot latch, bounds check and squared coordinate
// differences. Depends on nts_pkg.
`default_nettype none

module nts_square (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire logic signed [nts_pkg::COORD_W-1:0] i_robot_x,
    input  wire logic signed [nts_pkg::COORD_W-1:0] i_robot_y,
    input  wire logic signed [nts_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [nts_pkg::COORD_W-1:0] i_point_y,
    input  wire logic                              i_point_present,
    input  wire logic                              i_first_item,
    input  wire logic                              i_last_item,
    input  wire nts_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_b_go,
    output      logic                              o_b_valid,
    output nts_pkg::t_sq_item                      o_b
);

    // Input stage
    logic                               r_a_vld;
    logic signed [nts_pkg::COORD_W-1:0] r_a_rx;
    logic signed [nts_pkg::COORD_W-1:0] r_a_ry;
    logic signed [nts_pkg::COORD_W-1:0] r_a_px;
    logic signed [nts_pkg::COORD_W-1:0] r_a_py;
    logic                               r_a_pres;
    logic                               r_a_first;
    logic                               r_a_last;
    // Robot position held across a scan
    logic signed [nts_pkg::COORD_W-1:0] r_hold_x;
    logic signed [nts_pkg::COORD_W-1:0] r_hold_y;
    // Square stage
    logic                               r_b_vld;
    nts_pkg::t_sq_item                  r_b;
    nts_pkg::t_sq_item                  n_b;

    logic                               b_free;
    logic                               a_go;
    logic                               in_go;
    logic signed [nts_pkg::COORD_W-1:0] rob_x;
    logic signed [nts_pkg::COORD_W-1:0] rob_y;
    logic                               in_box;
    logic signed [nts_pkg::DIFF_W-1:0]  dhx;
    logic signed [nts_pkg::DIFF_W-1:0]  dhy;
    logic signed [nts_pkg::DIFF_W-1:0]  drx;
    logic signed [nts_pkg::DIFF_W-1:0]  dry;

    // Advance when the next stage is empty or moving
    assign b_free  = !r_b_vld || i_b_go;
    assign a_go    = r_a_vld && b_free;
    assign o_ready = !r_a_vld || a_go;
    assign in_go   = i_valid && o_ready;

    // Robot for this item: fresh on a first item, else the held one
    assign rob_x = r_a_first ? r_a_rx : r_hold_x;
    assign rob_y = r_a_first ? r_a_ry : r_hold_y;

    // Strictly inside the arena on both axes
    assign in_box = (r_a_px > i_cfg.arena_low) && (r_a_px < i_cfg.arena_high) &&
                    (r_a_py > i_cfg.arena_low) && (r_a_py < i_cfg.arena_high);

    assign dhx = nts_pkg::DIFF_W'(r_a_px) - nts_pkg::DIFF_W'(i_cfg.home_x);
    assign dhy = nts_pkg::DIFF_W'(r_a_py) - nts_pkg::DIFF_W'(i_cfg.home_y);
    assign drx = nts_pkg::DIFF_W'(r_a_px) - nts_pkg::DIFF_W'(rob_x);
    assign dry = nts_pkg::DIFF_W'(r_a_py) - nts_pkg::DIFF_W'(rob_y);

    // Build the squared item
    always_comb begin
        n_b.first = r_a_first;
        n_b.last  = r_a_last;
        n_b.ok    = r_a_pres && in_box;
        n_b.hx2   = nts_pkg::sq_diff(dhx);
        n_b.hy2   = nts_pkg::sq_diff(dhy);
        n_b.rx2   = nts_pkg::sq_diff(drx);
        n_b.ry2   = nts_pkg::sq_diff(dry);
        n_b.px    = r_a_px;
        n_b.py    = r_a_py;
        n_b.rx    = rob_x;
        n_b.ry    = rob_y;
    end

    // Valid bits and held robot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_hold_x <= '0;
            r_hold_y <= '0;
        end else begin
            if (o_ready) begin
                r_a_vld <= i_valid;
            end
            if (b_free) begin
                r_b_vld <= a_go;
            end
            if (a_go && r_a_first) begin
                r_hold_x <= r_a_rx;
                r_hold_y <= r_a_ry;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_a_rx    <= i_robot_x;
            r_a_ry    <= i_robot_y;
            r_a_px    <= i_point_x;
            r_a_py    <= i_point_y;
            r_a_pres  <= i_point_present;
            r_a_first <= i_first_item;
            r_a_last  <= i_last_item;
        end
        if (a_go) begin
            r_b <= n_b;
        end
    end

    assign o_b_valid = r_b_vld;
    assign o_b       = r_b;

endmodule

`default_nettype wire

FILE: design/nts_select.sv
// Distance sums, exclusion and best-distance compare, scan state and the
// result register. Depends on nts_pkg.
`default_nettype none

module nts_select (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_b_valid,
    input  wire nts_pkg::t_sq_item                 i_b,
    input  wire nts_pkg::t_cfg                     i_cfg,
    output      logic                              o_b_go,
    input  wire logic                              i_m_ready,
    output      logic                              o_m_valid,
    output      logic signed [nts_pkg::COORD_W-1:0] o_target_x,
    output      logic signed [nts_pkg::COORD_W-1:0] o_target_y,
    output      logic                              o_target_found
);

    logic [nts_pkg::DIST_W-1:0]         r_best;
    logic [nts_pkg::DIST_W-1:0]         n_best;
    logic signed [nts_pkg::COORD_W-1:0] r_best_x;
    logic signed [nts_pkg::COORD_W-1:0] r_best_y;
    logic signed [nts_pkg::COORD_W-1:0] n_best_x;
    logic signed [nts_pkg::COORD_W-1:0] n_best_y;
    logic                               r_have;
    logic                               n_have;
    logic                               r_out_vld;
    logic signed [nts_pkg::COORD_W-1:0] r_tx;
    logic signed [nts_pkg::COORD_W-1:0] r_ty;
    logic                               r_found;

    logic                               out_free;
    logic                               go;
    logic [nts_pkg::DIST_W-1:0]         d_home;
    logic [nts_pkg::DIST_W-1:0]         d_rob;
    logic [nts_pkg::DIST_W-1:0]         bar;
    logic                               take;

    // A result item needs room in the output register; others always pass
    assign out_free = !r_out_vld || i_m_ready;
    assign go       = i_b_valid && (!i_b.last || out_free);
    assign o_b_go   = go;

    assign d_home = nts_pkg::DIST_W'(i_b.hx2) + nts_pkg::DIST_W'(i_b.hy2);
    assign d_rob  = nts_pkg::DIST_W'(i_b.rx2) + nts_pkg::DIST_W'(i_b.ry2);
    // A first item restarts from the limit
    assign bar    = i_b.first ? nts_pkg::DIST_W'(i_cfg.lim_sq) : r_best;
    assign take   = go && i_b.ok && (d_home > nts_pkg::DIST_W'(i_cfg.rad_sq)) &&
                    (d_rob < bar);

    // Next scan state
    always_comb begin
        n_best   = r_best;
        n_best_x = r_best_x;
        n_best_y = r_best_y;
        n_have   = r_have;
        if (go && i_b.first) begin
            n_best = bar;
            n_have = 1'b0;
        end
        if (take) begin
            n_best   = d_rob;
            n_best_x = i_b.px;
            n_best_y = i_b.py;
            n_have   = 1'b1;
        end
    end

    // Scan state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best    <= '0;
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_best <= n_best;
            r_have <= n_have;
            if (go && i_b.last) begin
                r_out_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Best point and result payload
    always_ff @(posedge i_clk) begin
        r_best_x <= n_best_x;
        r_best_y <= n_best_y;
        if (go && i_b.last) begin
            r_tx    <= n_have ? n_best_x : i_b.rx;
            r_ty    <= n_have ? n_best_y : i_b.ry;
            r_found <= n_have;
        end
    end

    assign o_m_valid      = r_out_vld;
    assign o_target_x     = r_tx;
    assign o_target_y     = r_ty;
    assign o_target_found = r_found;

    // A new best inside a running scan is strictly nearer
    a_best_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_b.first) |=> (r_best < $past(r_best)))
        else $error("best distance did not shrink on a new best point");

    // A first item without a qualifying point leaves no best
    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && i_b.first && !take) |=> !r_have)
        else $error("first item did not clear the best point");

    // A last item always lands in the output register
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && i_b.last) |=> r_out_vld)
        else $error("last item produced no result");

    // The squared stage never passes a last item into a full output
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_ready) |-> !(go && i_b.last))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: design/nearest_target_select_top.sv
// Nearest target selector top level: configuration registers, squaring
// stage and selection stage. Depends on nts_pkg, nts_cfg, nts_square, nts_select.
//
// Use: each input item carries one candidate point and the robot position.
// tuser[1] starts a scan (latches the robot, restarts the best distance at
// search_limit squared), tuser[0] says a point is present, tlast ends the
// scan. At tlast one result item leaves: the nearest qualifying point with
// target_found = 1, or the latched robot position with target_found = 0.
// Items without tlast produce nothing.
// Throughput: one item per cycle, sustained while no tlast item waits for a
// full result register; the best-distance compare and update are
// combinational and registered in the selection stage.
// Path: a last item loads the input register when accepted, then the
// squaring register, then the result register.
// Stall: the result register holds while m_axis_tready is low; items without
// tlast keep flowing, and a second tlast item waits in the squaring stage,
// which then lowers s_axis_tready once the input register is full too.
// Reset (synchronous, active low) loads register defaults, clears the scan
// state and empties every stage. Write configuration only while idle.
`default_nettype none

module nearest_target_select_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [nts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [nts_pkg::COORD_W-1:0]       i_cfg_data,
    // Candidate items
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // robot_x, robot_y, point_x, point_y (lowest bits first)
    input  wire logic [nts_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // point_present, first_item (lowest bit first)
    input  wire logic [nts_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    // Result items
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // target_x, target_y (lowest bits first), zero padded
    output      logic [nts_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // target_found
    output      logic [nts_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    localparam int CW = nts_pkg::COORD_W;

    nts_pkg::t_cfg              cfg;
    nts_pkg::t_sq_item          sq_item;
    logic                       sq_valid;
    logic                       sq_go;
    logic signed [CW-1:0]       target_x;
    logic signed [CW-1:0]       target_y;
    logic                       target_found;

    nts_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    nts_square u_square (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_robot_x       (s_axis_tdata[CW-1:0]),
        .i_robot_y       (s_axis_tdata[2*CW-1:CW]),
        .i_point_x       (s_axis_tdata[3*CW-1:2*CW]),
        .i_point_y       (s_axis_tdata[4*CW-1:3*CW]),
        .i_point_present (s_axis_tuser[0]),
        .i_first_item    (s_axis_tuser[1]),
        .i_last_item     (s_axis_tlast),
        .i_cfg           (cfg),
        .i_b_go          (sq_go),
        .o_b_valid       (sq_valid),
        .o_b             (sq_item)
    );

    nts_select u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_b_valid      (sq_valid),
        .i_b            (sq_item),
        .i_cfg          (cfg),
        .o_b_go         (sq_go),
        .i_m_ready      (m_axis_tready),
        .o_m_valid      (m_axis_tvalid),
        .o_target_x     (target_x),
        .o_target_y     (target_y),
        .o_target_found (target_found)
    );

    // Pack the result item
    assign m_axis_tdata = nts_pkg::M_TDATA_W'({target_y, target_x});
    assign m_axis_tuser = target_found;

endmodule

`default_nettype wire

FILE: tb/tb_nearest_target_select_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_target_select_top: a directed table, then random
// scans under several register settings, checked against typed table values
// or an in-bench predictor. Depends on nts_pkg and the design sources under design/.

module tb_nearest_target_select_top;

    localparam int CLK_HALF       = 4;
    localparam int RST_CYCLES     = 12;
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = 4 * RESULT_LATENCY;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_ITEMS    = 226;

    // Indexes past the register list; writes there must change nothing
    localparam logic [nts_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [nts_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [nts_pkg::COORD_W-1:0] t_coord;

    typedef struct {
        t_coord rx;
        t_coord ry;
        t_coord px;
        t_coord py;
        logic   present;
        logic   first;
        logic   last;
    } t_cand;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   found;
    } t_target;

    typedef struct {
        t_cand   c;
        bit      typed;
        t_target want;
    } t_dir_row;

    // DUT connections, all inputs known from time zero
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [nts_pkg::CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [nts_pkg::COORD_W-1:0]     i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [nts_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [nts_pkg::S_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [nts_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic [nts_pkg::M_TUSER_W-1:0]   m_axis_tuser;

    // Register copies held by the predictor
    t_coord                      arena_lo_q   = t_coord'(nts_pkg::ARENA_LOW_RST);
    t_coord                      arena_hi_q   = t_coord'(nts_pkg::ARENA_HIGH_RST);
    logic [nts_pkg::RAD_W-1:0]   excl_rad_q   = nts_pkg::RAD_W'(nts_pkg::RADIUS_RST);
    t_coord                      home_x_q     = t_coord'(nts_pkg::HOME_X_RST);
    t_coord                      home_y_q     = t_coord'(nts_pkg::HOME_Y_RST);
    logic [nts_pkg::COORD_W-1:0] search_lim_q = nts_pkg::COORD_W'(nts_pkg::LIMIT_RST);

    // Scan state held by the predictor
    longint near_dsq = 0;
    t_coord near_x   = '0;
    t_coord near_y   = '0;
    logic   near_ok  = 1'b0;
    t_coord anchor_x = '0;
    t_coord anchor_y = '0;

    t_target  target_q[$];
    t_dir_row dir_rows[$];
    t_coord   prev_px = '0;
    t_coord   prev_py = '0;
    int       src_idle_pct = 0;
    int       snk_idle_pct = 0;
    int       err_count = 0;
    int       cycle_cnt = 0;

    nearest_target_select_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Advance the scan by one item; return 1 when the item ends a scan
    function automatic bit predict_target(input t_cand c, output t_target t);
        longint d_home;
        longint d_robot;
        if (c.first) begin
            anchor_x = c.rx;
            anchor_y = c.ry;
            near_dsq = longint'(search_lim_q) * longint'(search_lim_q);
            near_ok  = 1'b0;
        end
        if (c.present && c.px > arena_lo_q && c.px < arena_hi_q
                && c.py > arena_lo_q && c.py < arena_hi_q) begin
            d_home = (longint'(c.px) - longint'(home_x_q)) ** 2
                   + (longint'(c.py) - longint'(home_y_q)) ** 2;
            d_robot = (longint'(c.px) - longint'(anchor_x)) ** 2
                    + (longint'(c.py) - longint'(anchor_y)) ** 2;
            if (d_home > longint'(excl_rad_q) * longint'(excl_rad_q) && d_robot < near_dsq) begin
                near_dsq = d_robot;
                near_x   = c.px;
                near_y   = c.py;
                near_ok  = 1'b1;
            end
        end
        t.x     = near_ok ? near_x : anchor_x;
        t.y     = near_ok ? near_y : anchor_y;
        t.found = near_ok;
        return c.last;
    endfunction

    // Compare each result item with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_target got;
        t_target want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x     = m_axis_tdata[nts_pkg::COORD_W-1:0];
            got.y     = m_axis_tdata[2*nts_pkg::COORD_W-1:nts_pkg::COORD_W];
            got.found = m_axis_tuser[0];
            if (target_q.size() == 0) begin
                report_mismatch("result with nothing pending, target_x", int'(got.x), 0);
            end else begin
                want = target_q.pop_front();
                if (got.x != want.x)
                    report_mismatch("target_x", int'(got.x), int'(want.x));
                if (got.y != want.y)
                    report_mismatch("target_y", int'(got.y), int'(want.y));
                if (got.found != want.found)
                    report_mismatch("target_found", int'(got.found), int'(want.found));
            end
        end
    end

    // Present one item, hold it until accepted, then record what it should produce
    task automatic push_item(input t_cand c, input bit typed, input t_target want);
        t_target t;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nts_pkg::S_TDATA_W'({c.py, c.px, c.ry, c.rx});
        s_axis_tuser  <= {c.first, c.present};
        s_axis_tlast  <= c.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (predict_target(c, t))
            target_q.push_back(typed ? want : t);
    endtask

    // Drop valid and wait until every pending result is out and the pipe is empty
    task automatic hold_off();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (target_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [nts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nts_pkg::COORD_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            nts_pkg::REG_ARENA_LOW:  arena_lo_q   = val;
            nts_pkg::REG_ARENA_HIGH: arena_hi_q   = val;
            nts_pkg::REG_RADIUS:     excl_rad_q   = val[nts_pkg::RAD_W-1:0];
            nts_pkg::REG_HOME_X:     home_x_q     = val;
            nts_pkg::REG_HOME_Y:     home_y_q     = val;
            nts_pkg::REG_LIMIT:      search_lim_q = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input int lo, input int hi, input int rad,
                             input int hx, input int hy, input int lim);
        hold_off();
        write_reg(nts_pkg::REG_ARENA_LOW,  nts_pkg::COORD_W'(lo));
        write_reg(nts_pkg::REG_ARENA_HIGH, nts_pkg::COORD_W'(hi));
        write_reg(nts_pkg::REG_RADIUS,     nts_pkg::COORD_W'(rad));
        write_reg(nts_pkg::REG_HOME_X,     nts_pkg::COORD_W'(hx));
        write_reg(nts_pkg::REG_HOME_Y,     nts_pkg::COORD_W'(hy));
        write_reg(nts_pkg::REG_LIMIT,      nts_pkg::COORD_W'(lim));
        write_reg(REG_SPARE_LO,            nts_pkg::COORD_W'($urandom));
        write_reg(REG_SPARE_HI,            nts_pkg::COORD_W'($urandom));
    endtask

    // Coordinate mostly inside the arena, sometimes on or next to a bound
    function automatic t_coord pick_coord();
        int sel;
        int span;
        sel = $urandom_range(99);
        if (sel < 20 || arena_lo_q >= arena_hi_q)
            return t_coord'($urandom);
        if (sel < 30) begin
            case ($urandom_range(3))
                0: return arena_lo_q;
                1: return arena_lo_q + t_coord'(1);
                2: return arena_hi_q;
                default: return arena_hi_q - t_coord'(1);
            endcase
        end
        span = int'(arena_hi_q) - int'(arena_lo_q);
        return t_coord'(int'(arena_lo_q) + int'($urandom_range(span)));
    endfunction

    // Candidate near the robot, on the exclusion edge, a repeat, or anywhere
    task automatic pick_point(input t_coord rx, input t_coord ry,
                              output t_coord px, output t_coord py);
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            px = t_coord'(int'(rx) + int'($urandom_range(400)) - 200);
            py = t_coord'(int'(ry) + int'($urandom_range(400)) - 200);
        end else if (sel < 20) begin
            px = t_coord'(int'(home_x_q) + int'(excl_rad_q));
            py = home_y_q + t_coord'($urandom_range(1));
        end else if (sel < 25) begin
            px = prev_px;
            py = prev_py;
        end else begin
            px = pick_coord();
            py = pick_coord();
        end
        prev_px = px;
        prev_py = py;
    endtask

    // Mostly well-formed scans, some loose items with random flags
    task automatic run_scans(input int n_items);
        t_cand   c;
        t_target none;
        int      sent;
        int      len;
        t_coord  rx;
        t_coord  ry;
        sent = 0;
        none = '{x: '0, y: '0, found: 1'b0};
        while (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
                c.rx      = t_coord'($urandom);
                c.ry      = t_coord'($urandom);
                c.px      = t_coord'($urandom);
                c.py      = t_coord'($urandom);
                c.present = 1'($urandom_range(1));
                c.first   = 1'($urandom_range(1));
                c.last    = 1'($urandom_range(1));
                push_item(c, 1'b0, none);
                if (c.present || c.first || c.last)
                    sent++;
            end else begin
                len = $urandom_range(7);
                rx  = pick_coord();
                ry  = pick_coord();
                for (int k = 0; k <= len; k++) begin
                    c.rx      = (k == 0) ? rx : t_coord'($urandom);
                    c.ry      = (k == 0) ? ry : t_coord'($urandom);
                    c.present = ($urandom_range(99) < 85);
                    c.first   = (k == 0);
                    c.last    = (k == len);
                    pick_point(rx, ry, c.px, c.py);
                    push_item(c, 1'b0, none);
                    sent++;
                end
            end
            // Now and then let the pipe run dry
            if ($urandom_range(149) == 0)
                hold_off();
        end
    endtask

    function automatic t_dir_row dir_row(input int rx, input int ry, input int px, input int py,
                                         input bit pr, input bit fi, input bit la,
                                         input bit typed, input int tx, input int ty,
                                         input bit tf);
        t_dir_row r;
        r.c.rx       = t_coord'(rx);
        r.c.ry       = t_coord'(ry);
        r.c.px       = t_coord'(px);
        r.c.py       = t_coord'(py);
        r.c.present  = pr;
        r.c.first    = fi;
        r.c.last     = la;
        r.typed      = typed;
        r.want.x     = t_coord'(tx);
        r.want.y     = t_coord'(ty);
        r.want.found = tf;
        return r;
    endfunction

    // Run timeout
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_nearest_target_select_top: FAIL");
        $finish;
    end

    initial begin
        // Directed rows under reset register values
        // Before any scan start: nothing can qualify, robot reads back as zero
        dir_rows.push_back(dir_row(0, 0, 1000, 1000, 1, 0, 1, 1, 0, 0, 0));
        // Empty scan marker: start and end with no point
        dir_rows.push_back(dir_row(500, 600, 0, 0, 0, 1, 1, 1, 500, 600, 0));
        // Nearer point wins, equal distance keeps the earlier point
        dir_rows.push_back(dir_row(1000, 1000, 1200, 1000, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(-1, -1, 1100, 1000, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 900, 1000, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 0, 0, 0, 0, 1, 1, 1100, 1000, 1));
        // Items after the end of a scan keep adding to it
        dir_rows.push_back(dir_row(0, 0, 1050, 1000, 1, 0, 1, 1, 1050, 1000, 1));
        // Points on the bounds, inside and exactly on the exclusion circle
        dir_rows.push_back(dir_row(10, 10, 0, 5, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 5, 2100, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 260, 260, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 550, 250, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 2099, 1, 1, 0, 1, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 550, 251, 1, 1, 1, 0, 0, 0, 0));
        // Field extremes: points far outside the arena
        dir_rows.push_back(dir_row(-8192, 8191, 8191, -8192, 1, 1, 1, 1, -8192, 8191, 0));
        dir_rows.push_back(dir_row(8191, -8192, -8192, 8191, 1, 1, 1, 1, 8191, -8192, 0));
        dir_rows.push_back(dir_row(-8192, -8192, -8192, -8192, 1, 1, 1, 1, -8192, -8192, 0));
        dir_rows.push_back(dir_row(8191, 8191, 8191, 8191, 1, 1, 1, 1, 8191, 8191, 0));
        // Distance equal to the search limit does not qualify, one step closer does
        dir_rows.push_back(dir_row(-1000, 100, 1400, 1900, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 1399, 1900, 1, 0, 1, 0, 0, 0, 0));
        // Empty items inside a scan
        dir_rows.push_back(dir_row(300, 300, 700, 700, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));

        src_idle_pct = 27;
        snk_idle_pct = 50;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            push_item(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

        // Random scans under several register settings
        load_regs(-3000, 3000, 300, 0, 0, 3000);
        run_scans(PHASE_ITEMS);
        load_regs(-8192, 8191, 8191, -8192, 8191, 16383);
        run_scans(PHASE_ITEMS);

        src_idle_pct = 50;
        snk_idle_pct = 27;
        // Inverted bounds, zero radius, zero limit: nothing qualifies
        load_regs(8191, -8192, 0, 8191, -8192, 0);
        run_scans(PHASE_ITEMS);
        load_regs(-int'($urandom_range(8192)), $urandom_range(8191), $urandom_range(8191),
                  int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192,
                  $urandom_range(16383));
        run_scans(PHASE_ITEMS);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_regs(-1500, 1500, 100, 200, -200, 2500);
        run_scans(PHASE_ITEMS);

        hold_off();
        if (err_count == 0) begin
            $display("tb_nearest_target_select_top: PASS");
        end else begin
            $display("tb_nearest_target_select_top: FAIL");
        end
        $finish;
    end

endmodule
